FILE: rtl/core/fdsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsd_pkg
// Shared types, constants and segment lookup for the four-digit display
// formatter.
// ----------------------------------------------------------------------------
package fdsd_pkg;

   localparam int NUM_DIGITS      = 4;
   localparam int NUM_BCD         = 10;
   localparam int DABBLE_STEPS    = 8;
   localparam int NUM_DABBLE      = 4;
   localparam int SEG_W           = 7;

   localparam logic       ACTION_NUMBER = 1'b0;
   localparam logic       ACTION_CHARS  = 1'b1;
   localparam logic [2:0] SLOT_BLANK    = 3'd4;

   localparam logic [6:0] SEG_MINUS = 7'h40;
   localparam logic [6:0] SEG_A     = 7'h77;
   localparam logic [6:0] SEG_OFF   = 7'h00;

   typedef logic [NUM_DIGITS-1:0][SEG_W-1:0] segs_type;

   // one word in flight through the binary to decimal stages
   typedef struct packed {
      logic                      action;
      logic                      neg;
      logic [NUM_DIGITS-1:0][7:0] chars;
      logic [31:0]               bin;
      logic [NUM_BCD-1:0][3:0]   bcd;
   } conv_type;

   // after the digit count has been found
   typedef struct packed {
      logic                      action;
      logic                      neg;
      logic                      short_text;
      logic [3:0]                num_digits;
      logic [3:0]                text_len;
      logic [NUM_DIGITS-1:0][7:0] chars;
      logic [NUM_BCD-1:0][3:0]   bcd;
   } fmt_type;

   function automatic logic [6:0] seg_of_digit(input logic [3:0] d);
      logic [6:0] s;
      case (d)
         4'd0:    s = 7'h3F;
         4'd1:    s = 7'h06;
         4'd2:    s = 7'h5B;
         4'd3:    s = 7'h4F;
         4'd4:    s = 7'h66;
         4'd5:    s = 7'h6D;
         4'd6:    s = 7'h7D;
         4'd7:    s = 7'h07;
         4'd8:    s = 7'h7F;
         4'd9:    s = 7'h6F;
         default: s = SEG_OFF;
      endcase
      return s;
   endfunction

   function automatic logic [6:0] seg_of_char(input logic [7:0] ch);
      logic [6:0] s;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         s = seg_of_digit(ch[3:0]);
      end else if (ch == 8'h2D) begin
         s = SEG_MINUS;
      end else if (ch == 8'h61 || ch == 8'h41) begin
         s = SEG_A;
      end else begin
         s = SEG_OFF;
      end
      return s;
   endfunction

endpackage

FILE: rtl/core/fdsd_dabble.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsd_dabble
// One register stage of the binary to BCD converter: eight shift-and-add-3
// steps on the word passing through.
// ----------------------------------------------------------------------------
module fdsd_dabble (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   output logic              up_ready,
   input  fdsd_pkg::conv_type up_data,
   output logic              dn_valid,
   input  logic              dn_ready,
   output fdsd_pkg::conv_type dn_data
);
   import fdsd_pkg::*;

   logic     valid_ff;
   conv_type data_ff;
   conv_type data_in;

   always_comb begin
      data_in = up_data;
      for (int s = 0; s < DABBLE_STEPS; s++) begin
         for (int g = 0; g < NUM_BCD; g++) begin
            if (data_in.bcd[g] >= 4'd5) begin
               data_in.bcd[g] = data_in.bcd[g] + 4'd3;
            end
         end
         {data_in.bcd, data_in.bin} = {data_in.bcd, data_in.bin} << 1;
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

FILE: rtl/core/fdsd_format.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsd_format
// Two register stages: count the decimal digits, then pick the four shown
// characters and look up their segment patterns.
// ----------------------------------------------------------------------------
module fdsd_format (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  fdsd_pkg::conv_type up_data,
   output logic               dn_valid,
   input  logic               dn_ready,
   output fdsd_pkg::segs_type dn_segs
);
   import fdsd_pkg::*;

   logic     cnt_valid_ff;
   fmt_type  cnt_ff;
   fmt_type  cnt_in;
   logic     cnt_ready;
   logic     seg_valid_ff;
   segs_type seg_ff;
   segs_type seg_in;

   // stage 1: digit count and text length
   always_comb begin
      cnt_in.action     = up_data.action;
      cnt_in.neg        = up_data.neg;
      cnt_in.chars      = up_data.chars;
      cnt_in.bcd        = up_data.bcd;
      cnt_in.num_digits = 4'd1;
      for (int i = 0; i < NUM_BCD; i++) begin
         if (up_data.bcd[i] != 4'd0) begin
            cnt_in.num_digits = 4'(i + 1);
         end
      end
      cnt_in.text_len   = cnt_in.num_digits + {3'd0, up_data.neg};
      cnt_in.short_text = cnt_in.text_len < 4'(NUM_DIGITS);
   end

   assign cnt_ready = !seg_valid_ff || dn_ready;
   assign up_ready  = !cnt_valid_ff || cnt_ready;

   // stage 2: character selection per display position
   always_comb begin
      logic [3:0] pos;
      logic [3:0] pad;
      logic       is_blank;
      logic       is_minus;
      pos      = 4'd0;
      pad      = 4'(NUM_DIGITS) - cnt_ff.text_len;
      is_blank = 1'b0;
      is_minus = 1'b0;
      seg_in   = '0;
      for (int k = 0; k < NUM_DIGITS; k++) begin
         if (cnt_ff.short_text) begin
            // right-justified: position k shows digit 3-k
            pos      = 4'(NUM_DIGITS - 1 - k);
            is_blank = 4'(k) < pad;
            is_minus = cnt_ff.neg && (4'(k) == pad);
         end else begin
            // truncated: leading characters of the full text
            pos      = cnt_ff.num_digits - 4'(1 + k) + {3'd0, cnt_ff.neg};
            is_blank = 1'b0;
            is_minus = cnt_ff.neg && (k == 0);
         end
         if (cnt_ff.action == ACTION_CHARS) begin
            seg_in[k] = seg_of_char(cnt_ff.chars[k]);
         end else if (is_blank) begin
            seg_in[k] = SEG_OFF;
         end else if (is_minus) begin
            seg_in[k] = SEG_MINUS;
         end else if (pos < 4'(NUM_BCD)) begin
            seg_in[k] = seg_of_digit(cnt_ff.bcd[pos]);
         end else begin
            seg_in[k] = SEG_OFF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_valid_ff <= 1'b0;
         seg_valid_ff <= 1'b0;
      end else begin
         if (up_ready) begin
            cnt_valid_ff <= up_valid;
         end
         if (cnt_ready) begin
            seg_valid_ff <= cnt_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         cnt_ff <= cnt_in;
      end
      if (cnt_ready) begin
         seg_ff <= seg_in;
      end
   end

   assign dn_valid = seg_valid_ff;
   assign dn_segs  = seg_ff;

endmodule

FILE: rtl/core/fdsd_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsd_scan
// Holds four segment patterns and sends them out one digit per word,
// followed by the blanking word.
// ----------------------------------------------------------------------------
module fdsd_scan (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  fdsd_pkg::segs_type up_segs,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [3:0]         out_enable,
   output logic [6:0]         out_segs,
   output logic               out_last
);
   import fdsd_pkg::*;

   logic     busy_ff;
   logic [2:0] slot_ff;
   segs_type segs_ff;
   logic     at_end;

   assign at_end   = (slot_ff == SLOT_BLANK);
   assign up_ready = !busy_ff || (out_ready && at_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         slot_ff <= 3'd0;
      end else if (up_ready) begin
         busy_ff <= up_valid;
         slot_ff <= 3'd0;
      end else if (out_ready) begin
         slot_ff <= slot_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         segs_ff <= up_segs;
      end
   end

   assign out_valid  = busy_ff;
   assign out_last   = at_end;
   assign out_enable = at_end ? 4'b1000 : (4'b0001 << slot_ff[1:0]);
   assign out_segs   = at_end ? SEG_OFF : segs_ff[slot_ff[1:0]];

endmodule

FILE: rtl/core/four_digit_segment_display_formatter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_digit_segment_display_formatter_unit
// Turns a signed number or four character codes into five seven-segment
// scan words: one per digit, then a blanking word marked with tlast.
//
// channel  dir  tdata                                  tuser    tlast
// req      in   number[31:0] char_0..char_3[63:32]     action   -
// rsp      out  digit_enable[3:0] segments[10:4]       -        last
//
// The first word leaves after the item has passed four conversion stages,
// two formatting stages and the scan register. The scan register sends five
// words per item and takes the next item as the last word leaves, while the
// stages before it keep taking items. A stall on rsp holds each full stage in
// place while empty stages still fill; up to seven items wait in the pipeline.
// Reset clears all valid bits and the scan counter.
// ----------------------------------------------------------------------------
module four_digit_segment_display_formatter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // number[31:0], char_0, char_1, char_2, char_3
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // digit_enable[3:0], segments[10:4], zero fill
   output logic        rsp_tlast
);
   import fdsd_pkg::*;

   conv_type conv_data  [NUM_DABBLE+1];
   logic     conv_valid [NUM_DABBLE+1];
   logic     conv_ready [NUM_DABBLE+1];
   logic [31:0] number_raw;
   logic        neg;
   segs_type    fmt_segs;
   logic        fmt_valid;
   logic        fmt_ready;
   logic [3:0]  digit_enable;
   logic [6:0]  segments;

   assign number_raw = req_tdata[31:0];
   assign neg        = (req_tuser == ACTION_NUMBER) && number_raw[31];

   always_comb begin
      conv_data[0].action = req_tuser;
      conv_data[0].neg    = neg;
      conv_data[0].chars  = req_tdata[63:32];
      conv_data[0].bin    = neg ? (32'd0 - number_raw) : number_raw;
      conv_data[0].bcd    = '0;
   end

   assign conv_valid[0] = req_tvalid;
   assign req_tready    = conv_ready[0];

   for (genvar g = 0; g < NUM_DABBLE; g++) begin : g_dabble
      fdsd_dabble u_dabble (
         .clock    (clock),
         .reset    (reset),
         .up_valid (conv_valid[g]),
         .up_ready (conv_ready[g]),
         .up_data  (conv_data[g]),
         .dn_valid (conv_valid[g+1]),
         .dn_ready (conv_ready[g+1]),
         .dn_data  (conv_data[g+1])
      );
   end

   fdsd_format u_format (
      .clock    (clock),
      .reset    (reset),
      .up_valid (conv_valid[NUM_DABBLE]),
      .up_ready (conv_ready[NUM_DABBLE]),
      .up_data  (conv_data[NUM_DABBLE]),
      .dn_valid (fmt_valid),
      .dn_ready (fmt_ready),
      .dn_segs  (fmt_segs)
   );

   fdsd_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (fmt_valid),
      .up_ready   (fmt_ready),
      .up_segs    (fmt_segs),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_enable (digit_enable),
      .out_segs   (segments),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, segments, digit_enable};

endmodule
